/* rtl/sha1md_pkg.sv */
// shared types and constants for the sha-1 message digest block
package sha1md_pkg;

    // sha-1 initial chaining values
    localparam logic [31:0] H_INIT_0 = 32'h67452301;
    localparam logic [31:0] H_INIT_1 = 32'hEFCDAB89;
    localparam logic [31:0] H_INIT_2 = 32'h98BADCFE;
    localparam logic [31:0] H_INIT_3 = 32'h10325476;
    localparam logic [31:0] H_INIT_4 = 32'hC3D2E1F0;

    // round constants, one per group of twenty rounds
    localparam logic [31:0] K_ROUND_0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND_3 = 32'hCA62C1D6;

    // first padding byte
    localparam logic [7:0] PAD_MARK = 8'h80;

    // block geometry
    localparam int         BLOCK_BITS = 512;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;

    // message byte word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } msg_word_t;

    // digest word
    typedef struct packed {
        logic [31:0] digest_0;
        logic [31:0] digest_1;
        logic [31:0] digest_2;
        logic [31:0] digest_3;
        logic [31:0] digest_4;
        logic        overflow_error;
    } digest_word_t;

    // classified command from the front end to the compression engine
    typedef struct packed {
        logic        has_byte;
        logic [7:0]  data;
        logic        finish;
        logic        fault;
        logic [63:0] bit_count;
    } cmd_t;

    // queue status seen by the front end and the engine
    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

endpackage

/* rtl/sha1md_front.sv */
// front end: accepts message words, keeps the bit count and classifies items
module sha1md_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    msg_valid,
    output logic                    msg_stall,
    input  sha1md_pkg::msg_word_t   msg,
    input  sha1md_pkg::queue_status_t q_status,
    output logic                    push,
    output sha1md_pkg::cmd_t        push_cmd
);
    import sha1md_pkg::*;

    logic [63:0] count_reg, count_next;
    logic        fault_reg, fault_next;
    logic        take_byte;
    logic        accept;
    logic [63:0] count_inc;

    assign msg_stall = q_status.full;
    assign accept    = msg_valid && !q_status.full;
    assign take_byte = msg.byte_valid && !fault_reg;
    assign count_inc = count_reg + 64'd8;

    // length count and overflow flag
    always_comb
    begin
        count_next = count_reg;
        fault_next = fault_reg;
        if (accept)
        begin
            if (take_byte)
            begin
                count_next = count_inc;
                if (count_inc == 64'd0)
                begin
                    fault_next = 1'b1;
                end
            end
            if (msg.last)
            begin
                count_next = 64'd0;
                fault_next = 1'b0;
            end
        end
    end

    // command toward the engine; idle items are dropped here
    always_comb
    begin
        push               = accept && (take_byte || msg.last);
        push_cmd.has_byte  = take_byte;
        push_cmd.data      = msg.data_byte;
        push_cmd.finish    = msg.last;
        push_cmd.fault     = msg.last && (fault_reg || (take_byte && count_inc == 64'd0));
        push_cmd.bit_count = take_byte ? count_inc : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 64'd0;
            fault_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            fault_reg <= fault_next;
        end
    end

endmodule

/* rtl/sha1md_queue.sv */
// short command queue between the front end and the compression engine
module sha1md_queue #(
    parameter int DEPTH = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  sha1md_pkg::cmd_t          push_cmd,
    input  logic                      pop,
    output sha1md_pkg::cmd_t          head_cmd,
    output sha1md_pkg::queue_status_t q_status
);
    import sha1md_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign q_status.full      = (count_reg == CNT_FULL);
    assign q_status.not_empty = (count_reg != '0);
    assign do_push            = push && !q_status.full;
    assign do_pop             = pop && q_status.not_empty;
    assign head_cmd           = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTH
    // count never goes past the depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_FULL)
        else $error("queue count out of range");
    // a push into a full queue is refused by holding the count
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.full && push && !pop) |=> q_status.full)
        else $error("queue lost its full state");
    // pointers agree with the count when the queue is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree while empty");
`endif

endmodule

/* rtl/sha1md_engine.sv */
// compression engine: block buffer, padding sequencer, 80-round core, digest register
module sha1md_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sha1md_pkg::queue_status_t q_status,
    input  sha1md_pkg::cmd_t          head_cmd,
    output logic                      pop,
    output logic                      digest_valid,
    input  logic                      digest_stall,
    output sha1md_pkg::digest_word_t  digest
);
    import sha1md_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PAD   = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_HADD  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [5:0]           fill_reg, fill_next;
    logic [6:0]           round_reg, round_next;
    logic                 fin_reg, fin_next;
    logic                 mark_reg, mark_next;
    logic                 len_blk_reg, len_blk_next;
    logic                 final_reg, final_next;
    logic                 out_valid_reg, out_valid_next;
    logic [4:0][31:0]     h_reg, h_next;
    logic [BLOCK_BITS-1:0] blk_reg, blk_next;
    logic [31:0]          a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]          a_next, b_next, c_next, d_next, e_next;
    logic [63:0]          len_reg, len_next;
    digest_word_t         out_reg, out_next;

    logic                 slot_free;
    logic [31:0]          w0, w2, w8, w13, w_mix, w_new;
    logic [31:0]          f_val, k_val, t_val;
    logic [4:0][31:0]     h_sum;
    logic [4:0][31:0]     h_init;
    logic [7:0]           pad_byte;

    assign h_init    = {H_INIT_4, H_INIT_3, H_INIT_2, H_INIT_1, H_INIT_0};
    assign slot_free = !out_valid_reg || !digest_stall;

    // message schedule window: word t at the top of the block register
    assign w0    = blk_reg[511:480];
    assign w2    = blk_reg[447:416];
    assign w8    = blk_reg[255:224];
    assign w13   = blk_reg[95:64];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    // round function and constant by round group
    always_comb
    begin
        case (round_reg) inside
            [7'd0:7'd19]:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = K_ROUND_0;
            end
            [7'd20:7'd39]:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K_ROUND_1;
            end
            [7'd40:7'd59]:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = K_ROUND_2;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K_ROUND_3;
            end
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + w0 + k_val;

    // chaining update after the last round
    assign h_sum[0] = h_reg[0] + a_reg;
    assign h_sum[1] = h_reg[1] + b_reg;
    assign h_sum[2] = h_reg[2] + c_reg;
    assign h_sum[3] = h_reg[3] + d_reg;
    assign h_sum[4] = h_reg[4] + e_reg;

    // padding byte: marker, zeros, then the big-endian bit count
    always_comb
    begin
        if (!mark_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if (len_blk_reg && fill_reg >= LEN_START)
        begin
            pad_byte = len_reg[63:56];
        end
        else
        begin
            pad_byte = 8'd0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        fin_next       = fin_reg;
        mark_next      = mark_reg;
        len_blk_next   = len_blk_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg && digest_stall;
        h_next         = h_reg;
        blk_next       = blk_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        len_next       = len_reg;
        out_next       = out_reg;
        pop            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    if (head_cmd.finish && head_cmd.fault)
                    begin
                        // length overflow: zero digest with the error flag
                        if (slot_free)
                        begin
                            pop            = 1'b1;
                            out_valid_next = 1'b1;
                            out_next       = '0;
                            out_next.overflow_error = 1'b1;
                            h_next         = h_init;
                            fill_next      = 6'd0;
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        fin_next   = head_cmd.finish;
                        mark_next  = 1'b0;
                        final_next = 1'b0;
                        len_next   = head_cmd.bit_count;
                        if (head_cmd.has_byte)
                        begin
                            blk_next  = {blk_reg[BLOCK_BITS-9:0], head_cmd.data};
                            fill_next = fill_reg + 6'd1;
                            if (fill_reg == LAST_BYTE)
                            begin
                                state_next = ST_ROUND;
                                round_next = 7'd0;
                                a_next     = h_reg[0];
                                b_next     = h_reg[1];
                                c_next     = h_reg[2];
                                d_next     = h_reg[3];
                                e_next     = h_reg[4];
                            end
                            else if (head_cmd.finish)
                            begin
                                state_next = ST_PAD;
                            end
                        end
                        else if (head_cmd.finish)
                        begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end

            ST_PAD:
            begin
                blk_next  = {blk_reg[BLOCK_BITS-9:0], pad_byte};
                fill_next = fill_reg + 6'd1;
                if (!mark_reg)
                begin
                    mark_next    = 1'b1;
                    len_blk_next = (fill_reg < LEN_START);
                end
                else if (len_blk_reg && fill_reg >= LEN_START)
                begin
                    len_next = {len_reg[55:0], 8'd0};
                end
                if (fill_reg == LAST_BYTE)
                begin
                    state_next = ST_ROUND;
                    round_next = 7'd0;
                    final_next = mark_reg && len_blk_reg;
                    a_next     = h_reg[0];
                    b_next     = h_reg[1];
                    c_next     = h_reg[2];
                    d_next     = h_reg[3];
                    e_next     = h_reg[4];
                end
            end

            ST_ROUND:
            begin
                a_next     = t_val;
                b_next     = a_reg;
                c_next     = {b_reg[1:0], b_reg[31:2]};
                d_next     = c_reg;
                e_next     = d_reg;
                blk_next   = {blk_reg[BLOCK_BITS-33:0], w_new};
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_HADD;
                end
            end

            ST_HADD:
            begin
                if (fin_reg && final_reg)
                begin
                    // final block done: hand out the digest and restart
                    if (slot_free)
                    begin
                        out_valid_next          = 1'b1;
                        out_next.digest_0       = h_sum[0];
                        out_next.digest_1       = h_sum[1];
                        out_next.digest_2       = h_sum[2];
                        out_next.digest_3       = h_sum[3];
                        out_next.digest_4       = h_sum[4];
                        out_next.overflow_error = 1'b0;
                        h_next                  = h_init;
                        fin_next                = 1'b0;
                        final_next              = 1'b0;
                        state_next              = ST_IDLE;
                    end
                end
                else
                begin
                    h_next = h_sum;
                    if (fin_reg)
                    begin
                        len_blk_next = 1'b1;
                        state_next   = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= 6'd0;
            round_reg     <= 7'd0;
            fin_reg       <= 1'b0;
            mark_reg      <= 1'b0;
            len_blk_reg   <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            h_reg         <= {H_INIT_4, H_INIT_3, H_INIT_2, H_INIT_1, H_INIT_0};
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            fin_reg       <= fin_next;
            mark_reg      <= mark_next;
            len_blk_reg   <= len_blk_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        len_reg <= len_next;
        out_reg <= out_next;
    end

    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

`ifndef SYNTH
    // the round counter stays inside the 80 rounds
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_reg <= LAST_ROUND))
        else $error("round counter past last round");
    // a block under compression leaves the fill count at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (fill_reg == 6'd0))
        else $error("fill count moved during compression");
    // a finished final block with a free slot produces a digest
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HADD && fin_reg && final_reg && slot_free) |=> out_valid_reg)
        else $error("final block did not produce a digest");
    // an overflow result carries an all-zero digest; the first and last words are checked
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.overflow_error) |->
        (out_reg.digest_0 == 32'd0 && out_reg.digest_4 == 32'd0))
        else $error("overflow result with nonzero digest");
    // commands are only taken while the engine is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE))
        else $error("command taken while busy");
`endif

endmodule

/* rtl/sha1_message_digest.sv */
// top level of the sha-1 message digest block
//
//  channel  direction  handshake                 word
//  msg      in         msg_valid / msg_stall     data_byte, byte_valid, last
//  digest   out        digest_valid / digest_stall  digest_0..4, overflow_error
//
// the engine loads a 64-byte block one byte at a time from the queue, then
// runs 80 rounds on the one-round-per-cycle compression core and one
// chaining add. the last word adds 9 to 72 padding bytes and one or two
// more compressions.
// reset clears the chaining words to the initial values and empties the queue.
// a stalled digest stays in its output register while bytes keep flowing
// through the queue; only the next digest waits for it.
module sha1_message_digest #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     msg_valid,
    output logic                     msg_stall,
    input  sha1md_pkg::msg_word_t    msg,
    output logic                     digest_valid,
    input  logic                     digest_stall,
    output sha1md_pkg::digest_word_t digest
);
    import sha1md_pkg::*;

    queue_status_t q_status;
    logic          push, pop;
    cmd_t          push_cmd, head_cmd;

    // byte intake and classification
    sha1md_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .msg_valid(msg_valid),
        .msg_stall(msg_stall),
        .msg      (msg),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // command queue
    sha1md_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .head_cmd(head_cmd),
        .q_status(q_status)
    );

    // compression and digest output
    sha1md_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .digest_valid(digest_valid),
        .digest_stall(digest_stall),
        .digest      (digest)
    );

endmodule

/* tb/sha1_digest_checker.sv */
// digest checker: tracks sha-1 state from accepted message words and compares digests
`timescale 1ns / 1ps

module sha1_digest_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     msg_valid,
    input  logic                     msg_stall,
    input  sha1md_pkg::msg_word_t    msg,
    input  logic                     digest_valid,
    input  logic                     digest_stall,
    input  sha1md_pkg::digest_word_t digest,
    output int                       fail_count,
    output int                       pending_count
);
    import sha1md_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // running hash state of the message being collected
    logic [31:0]  chain_h [0:4];
    logic [7:0]   block_buf [0:63];
    int           fill_cnt;
    logic [63:0]  msg_bits;
    logic         len_fault;

    // digests owed by the block, oldest first
    digest_word_t expected_digests [$];

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // back to the initial chaining values and an empty block
    function automatic void restart_message();
        chain_h[0] = H_INIT_0;
        chain_h[1] = H_INIT_1;
        chain_h[2] = H_INIT_2;
        chain_h[3] = H_INIT_3;
        chain_h[4] = H_INIT_4;
        for (int i = 0; i < 64; i++)
        begin
            block_buf[i] = 8'h00;
        end
        fill_cnt  = 0;
        msg_bits  = 64'd0;
        len_fault = 1'b0;
    endfunction

    // 80 rounds over the collected block, then fold into the chaining words
    function automatic void compress_block();
        logic [31:0] w [0:79];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {block_buf[4 * i], block_buf[4 * i + 1],
                    block_buf[4 * i + 2], block_buf[4 * i + 3]};
        end
        for (int i = 16; i < 80; i++)
        begin
            w[i] = rotl(w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16], 1);
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_ROUND_0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = K_ROUND_1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_ROUND_3;
            end
            t = rotl(a, 5) + f + e + w[i] + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] = chain_h[0] + a;
        chain_h[1] = chain_h[1] + b;
        chain_h[2] = chain_h[2] + c;
        chain_h[3] = chain_h[3] + d;
        chain_h[4] = chain_h[4] + e;
        fill_cnt = 0;
    endfunction

    // pad mark, zeros and big-endian bit length, spilling into a second block if needed
    function automatic void pad_message();
        block_buf[fill_cnt] = PAD_MARK;
        fill_cnt++;
        if (fill_cnt > int'(LEN_START))
        begin
            while (fill_cnt < 64)
            begin
                block_buf[fill_cnt] = 8'h00;
                fill_cnt++;
            end
            compress_block();
        end
        while (fill_cnt < int'(LEN_START))
        begin
            block_buf[fill_cnt] = 8'h00;
            fill_cnt++;
        end
        for (int i = 0; i < 8; i++)
        begin
            block_buf[int'(LEN_START) + i] = msg_bits[63 - 8 * i -: 8];
        end
        compress_block();
    endfunction

    // one accepted message word; a last word owes one digest
    function automatic void absorb_word(input msg_word_t word);
        digest_word_t owed;
        if (word.byte_valid && !len_fault)
        begin
            block_buf[fill_cnt] = word.data_byte;
            fill_cnt++;
            msg_bits = msg_bits + 64'd8;
            if (msg_bits == 64'd0)
                len_fault = 1'b1;
            if (fill_cnt == 64)
                compress_block();
        end
        if (word.last)
        begin
            if (len_fault)
            begin
                owed = '0;
                owed.overflow_error = 1'b1;
            end
            else
            begin
                pad_message();
                owed.digest_0       = chain_h[0];
                owed.digest_1       = chain_h[1];
                owed.digest_2       = chain_h[2];
                owed.digest_3       = chain_h[3];
                owed.digest_4       = chain_h[4];
                owed.overflow_error = 1'b0;
            end
            expected_digests.push_back(owed);
            restart_message();
        end
    endfunction

    // compare outgoing digests, then track incoming message words
    always @(posedge clk or negedge rst_n)
    begin
        digest_word_t want;
        if (!rst_n)
        begin
            restart_message();
            expected_digests.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (digest_valid && !digest_stall)
            begin
                if (expected_digests.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected digest word: %h %h %h %h %h err %b",
                                 digest.digest_0, digest.digest_1, digest.digest_2,
                                 digest.digest_3, digest.digest_4, digest.overflow_error);
                end
                else
                begin
                    want = expected_digests.pop_front();
                    if (digest.digest_0 !== want.digest_0 ||
                        digest.digest_1 !== want.digest_1 ||
                        digest.digest_2 !== want.digest_2 ||
                        digest.digest_3 !== want.digest_3 ||
                        digest.digest_4 !== want.digest_4 ||
                        digest.overflow_error !== want.overflow_error)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("digest mismatch: expected %h %h %h %h %h err %b",
                                     want.digest_0, want.digest_1, want.digest_2,
                                     want.digest_3, want.digest_4, want.overflow_error);
                            $display("                 got      %h %h %h %h %h err %b",
                                     digest.digest_0, digest.digest_1, digest.digest_2,
                                     digest.digest_3, digest.digest_4,
                                     digest.overflow_error);
                        end
                    end
                end
            end
            if (msg_valid && !msg_stall)
                absorb_word(msg);
            pending_count = expected_digests.size();
        end
    end

endmodule

/* tb/sha1_message_digest_tb.sv */
// testbench top: drives message words into the sha-1 block and gives the verdict
`timescale 1ns / 1ps

module sha1_message_digest_tb;
    import sha1md_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_WORDS = 1700;
    localparam int TAIL_CYCLES  = 400;
    localparam int MAX_GAP      = 18;
    localparam int MSG_BITS     = $bits(msg_word_t);

    logic         clk;
    logic         rst_n;
    logic         msg_valid;
    logic         msg_stall;
    msg_word_t    msg;
    logic         digest_valid;
    logic         digest_stall;
    digest_word_t digest;

    int fail_count;
    int pending_count;
    int cycle_cnt = 0;
    int sent_words = 0;
    int sender_steady = 0;

    sha1_message_digest i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    sha1_digest_checker i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .msg_valid     (msg_valid),
        .msg_stall     (msg_stall),
        .msg           (msg),
        .digest_valid  (digest_valid),
        .digest_stall  (digest_stall),
        .digest        (digest),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // wait length for one word; occasional stretches with no waiting at all
    task automatic draw_gap(inout int steady, output int gap);
        if (steady > 0)
        begin
            steady--;
            gap = 0;
        end
        else if ($urandom_range(0, 24) == 0)
        begin
            steady = $urandom_range(10, 40);
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, MAX_GAP);
        end
    endtask

    // present one word after a random gap and hold it until accepted
    task automatic send_item(input logic [7:0] data, input logic has_byte, input logic lst);
        int gap;
        draw_gap(sender_steady, gap);
        @(negedge clk);
        if (gap > 0)
        begin
            msg_valid <= 1'b0;
            msg       <= msg_word_t'(MSG_BITS'($urandom));
            repeat (gap) @(negedge clk);
        end
        msg_valid      <= 1'b1;
        msg.data_byte  <= data;
        msg.byte_valid <= has_byte;
        msg.last       <= lst;
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        if (has_byte || lst)
            sent_words++;
    endtask

    // sender holds off until every owed digest is out
    task automatic drain_digests();
        @(negedge clk);
        msg_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // message length: mostly short, often around the padding and block edges
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, 24);
        if (r == 9)
            return $urandom_range(0, 200);
        case ($urandom_range(0, 10))
            0:       return 55;
            1:       return 56;
            2:       return 57;
            3:       return 63;
            4:       return 64;
            5:       return 65;
            6:       return 119;
            7:       return 120;
            8:       return 121;
            9:       return 127;
            default: return 128;
        endcase
    endfunction

    // one message of random bytes with stray idle words; the last byte may ride on last
    task automatic send_message(input int len);
        bit fold;
        fold = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, fold && (k == len - 1));
        end
        if (!fold)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // digest side: stall each word for a random number of valid cycles
    initial
    begin
        int hold;
        int steady;
        steady = 0;
        hold   = 0;
        digest_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (digest_valid && !digest_stall)
                draw_gap(steady, hold);
            else if (digest_valid && hold > 0)
                hold--;
            @(negedge clk);
            digest_stall <= (hold > 0);
        end
    end

    // stimulus and verdict
    initial
    begin
        rst_n     = 1'b0;
        msg_valid = 1'b0;
        msg       = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // empty message, then an idle word and another empty message
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // byte 00 alone on a last word, then two FF bytes with the second on the last word
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        // "abc" with an idle word inside, closed by a last word whose byte is ignored; then 80 alone
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'hAA, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b1);
        drain_digests();

        // random messages
        sent_words = 0;
        while (sent_words < RANDOM_WORDS)
        begin
            send_message(pick_length());
            if ($urandom_range(0, 15) == 0)
                drain_digests();
        end

        // let everything owed come out, then watch for strays
        drain_digests();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sha1_message_digest.f */
rtl/sha1md_pkg.sv
rtl/sha1md_front.sv
rtl/sha1md_queue.sv
rtl/sha1md_engine.sv
rtl/sha1_message_digest.sv
tb/sha1_digest_checker.sv
tb/sha1_message_digest_tb.sv
